// ===== rtl/exvr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler XYZ vector rotator.
package exvr_pkg;

    // Widths of the CORDIC datapath and the rotation datapath
    localparam int CORDIC_W = 32;
    localparam int ANGLE_W  = 16;
    localparam int VEC_W    = 32;
    localparam int COMP_W   = 33;  // rotated component, magnitude below sqrt(3) * 2^31
    localparam int PROD_W   = 34;  // one rounded product
    localparam int SUM_W    = PROD_W + 1;
    localparam int MUL_W    = COMP_W + CORDIC_W;
    localparam int FRAC_W   = 30;

    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;
    localparam logic signed [CORDIC_W-1:0] HALF_PI  = 32'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] NEG_HALF_PI = -32'sd1073741824;
    localparam logic signed [VEC_W-1:0]    SAT_MAX  = 32'sh7fffffff;
    localparam logic signed [VEC_W-1:0]    SAT_MIN  = 32'sh80000000;

    typedef logic signed [CORDIC_W-1:0] q30_t;
    typedef logic signed [COMP_W-1:0]   comp_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    typedef struct packed {
        logic [VEC_W-1:0] val;
        logic             ovf;
    } sat_t;

    // Arctangent of 2^-i in binary angle units, 2^31 units = pi
    function automatic q30_t atan_unit(input int idx);
        q30_t res;
        unique case (idx)
            0:  res = 32'sd536870912;
            1:  res = 32'sd316933406;
            2:  res = 32'sd167458907;
            3:  res = 32'sd85004756;
            4:  res = 32'sd42667331;
            5:  res = 32'sd21354465;
            6:  res = 32'sd10679838;
            7:  res = 32'sd5340245;
            8:  res = 32'sd2670163;
            9:  res = 32'sd1335087;
            10: res = 32'sd667544;
            11: res = 32'sd333772;
            12: res = 32'sd166886;
            13: res = 32'sd83443;
            14: res = 32'sd41722;
            15: res = 32'sd20861;
            16: res = 32'sd10430;
            17: res = 32'sd5215;
            18: res = 32'sd2608;
            19: res = 32'sd1304;
            20: res = 32'sd652;
            21: res = 32'sd326;
            22: res = 32'sd163;
            23: res = 32'sd81;
            24: res = 32'sd41;
            25: res = 32'sd20;
            26: res = 32'sd10;
            27: res = 32'sd5;
            28: res = 32'sd3;
            29: res = 32'sd1;
            30: res = 32'sd1;
            default: res = '0;
        endcase
        return res;
    endfunction

    // Component times Q1.30 factor, rounded half up to Q16.16
    function automatic prod_t mul_round(input comp_t a, input q30_t k);
        logic signed [MUL_W-1:0] ae;
        logic signed [MUL_W-1:0] ke;
        logic signed [MUL_W-1:0] prod;
        ae   = MUL_W'(a);
        ke   = MUL_W'(k);
        prod = ae * ke + (MUL_W'(1) <<< (FRAC_W - 1));
        return prod[FRAC_W+PROD_W-1:FRAC_W];
    endfunction

    // Clamp a rotated component to 32 bits
    function automatic sat_t sat32(input comp_t v);
        sat_t res;
        if (v > COMP_W'(SAT_MAX)) begin
            res.val = SAT_MAX;
            res.ovf = 1'b1;
        end else if (v < COMP_W'(SAT_MIN)) begin
            res.val = SAT_MIN;
            res.ovf = 1'b1;
        end else begin
            res.val = v[VEC_W-1:0];
            res.ovf = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== rtl/exvr_cordic_cell.sv =====
// One CORDIC micro-rotation cell: a fixed shift and arctangent step, registered.
module exvr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  exvr_pkg::q30_t       x_in,
    input  exvr_pkg::q30_t       y_in,
    input  exvr_pkg::q30_t       z_in,
    input  logic                 flip_in,
    output exvr_pkg::q30_t       x_out,
    output exvr_pkg::q30_t       y_out,
    output exvr_pkg::q30_t       z_out,
    output logic                 flip_out
);

    exvr_pkg::q30_t x_reg, y_reg, z_reg;
    exvr_pkg::q30_t x_next, y_next, z_next;
    exvr_pkg::q30_t dx, dy;
    logic           flip_reg;

    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        // rotate towards zero residual angle
        if (!z_in[exvr_pkg::CORDIC_W-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - exvr_pkg::atan_unit(STAGE);
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + exvr_pkg::atan_unit(STAGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            flip_reg <= flip_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

// ===== rtl/exvr_rotate_stage.sv =====
// Planar rotation of one component pair by a cos/sin pair, two register stages.
module exvr_rotate_stage (
    input  logic             aclk,
    input  logic             en,
    input  exvr_pkg::comp_t  p_in,
    input  exvr_pkg::comp_t  q_in,
    input  exvr_pkg::comp_t  r_in,
    input  exvr_pkg::q30_t   c_in,
    input  exvr_pkg::q30_t   s_in,
    output exvr_pkg::comp_t  p_out,
    output exvr_pkg::comp_t  q_out,
    output exvr_pkg::comp_t  r_out
);

    exvr_pkg::prod_t pc_reg, qs_reg, ps_reg, qc_reg;
    exvr_pkg::comp_t r_a_reg;
    exvr_pkg::comp_t p_reg, q_reg, r_reg;
    logic signed [exvr_pkg::SUM_W-1:0] p_next, q_next;

    // products, each rounded on its own
    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg  <= exvr_pkg::mul_round(p_in, c_in);
            qs_reg  <= exvr_pkg::mul_round(q_in, s_in);
            ps_reg  <= exvr_pkg::mul_round(p_in, s_in);
            qc_reg  <= exvr_pkg::mul_round(q_in, c_in);
            r_a_reg <= r_in;
        end
    end

    always_comb begin
        p_next = exvr_pkg::SUM_W'(pc_reg) - exvr_pkg::SUM_W'(qs_reg);
        q_next = exvr_pkg::SUM_W'(ps_reg) + exvr_pkg::SUM_W'(qc_reg);
    end

    // rotated sums stay within the component width
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next[exvr_pkg::COMP_W-1:0];
            q_reg <= q_next[exvr_pkg::COMP_W-1:0];
            r_reg <= r_a_reg;
        end
    end

    assign p_out = p_reg;
    assign q_out = q_reg;
    assign r_out = r_reg;

endmodule

// ===== rtl/euler_xyz_vector_rotate.sv =====
// Top level: rotates a Q16.16 vector about x, then y, then z by three binary angles.
// Path: an item passes the vector delay line beside the CORDIC rows, the three rotation
//   stages and the output register before m_valid rises; an item held in the input skid
//   register enters when the pipeline next advances.
// Throughput: one item per cycle; the whole pipeline advances together whenever the
//   output register is empty or being taken, with a one-item skid register at the input.
// Reset: aresetn (synchronous, active low) clears the stage valid bits and the skid flag;
//   data registers are not reset.
module euler_xyz_vector_rotate #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_vec_x,
    input  logic signed [31:0]  s_vec_y,
    input  logic signed [31:0]  s_vec_z,
    input  logic signed [15:0]  s_angle_x,
    input  logic signed [15:0]  s_angle_y,
    input  logic signed [15:0]  s_angle_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic                m_overflow
);

    localparam int N     = ROTATION_STAGES;
    localparam int LAT   = N + 8;
    localparam int LANES = 3;

    // ------------------------------------------------------------------
    // Pipeline control: a single advance for every stage
    // ------------------------------------------------------------------
    logic             adv;
    logic [LAT-1:0]   vld_reg, vld_next;
    logic             skid_valid_reg;
    logic             ent_valid;

    logic signed [31:0] skid_x_reg, skid_y_reg, skid_z_reg;
    logic signed [15:0] skid_ax_reg, skid_ay_reg, skid_az_reg;

    logic signed [31:0] ent_x, ent_y, ent_z;
    logic signed [15:0] ang_w [LANES];

    assign adv       = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = !skid_valid_reg;
    assign ent_valid = skid_valid_reg || (s_valid && s_ready);

    // Take the item from the skid register first, otherwise straight from the port
    always_comb begin
        if (skid_valid_reg) begin
            ent_x     = skid_x_reg;
            ent_y     = skid_y_reg;
            ent_z     = skid_z_reg;
            ang_w[0]  = skid_ax_reg;
            ang_w[1]  = skid_ay_reg;
            ang_w[2]  = skid_az_reg;
        end else begin
            ent_x     = s_vec_x;
            ent_y     = s_vec_y;
            ent_z     = s_vec_z;
            ang_w[0]  = s_angle_x;
            ang_w[1]  = s_angle_y;
            ang_w[2]  = s_angle_z;
        end
    end

    // Hold an item in the skid register while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (adv) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_valid && s_ready) begin
            skid_x_reg  <= s_vec_x;
            skid_y_reg  <= s_vec_y;
            skid_z_reg  <= s_vec_z;
            skid_ax_reg <= s_angle_x;
            skid_ay_reg <= s_angle_y;
            skid_az_reg <= s_angle_z;
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], ent_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rows: one row of cells per angle, all three side by side
    // ------------------------------------------------------------------
    exvr_pkg::q30_t cx_w [LANES][N+1];
    exvr_pkg::q30_t cy_w [LANES][N+1];
    exvr_pkg::q30_t cz_w [LANES][N+1];
    logic           cf_w [LANES][N+1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        exvr_pkg::q30_t z0;
        logic           fold;

        // Angles beyond a quarter turn fold by a half turn; flipping the sign bit
        // of the 32-bit angle is that half turn, and a fold negates cos and sin
        assign z0   = {ang_w[l], {(exvr_pkg::CORDIC_W - exvr_pkg::ANGLE_W){1'b0}}};
        assign fold = (z0 > exvr_pkg::HALF_PI) || (z0 < exvr_pkg::NEG_HALF_PI);

        assign cx_w[l][0] = exvr_pkg::GAIN_Q30;
        assign cy_w[l][0] = '0;
        assign cz_w[l][0] = fold ? {~z0[exvr_pkg::CORDIC_W-1], z0[exvr_pkg::CORDIC_W-2:0]}
                                 : z0;
        assign cf_w[l][0] = fold;

        for (genvar k = 0; k < N; k++) begin : g_cell
            exvr_cordic_cell #(
                .STAGE (k)
            ) u_cell (
                .aclk     (aclk),
                .en       (adv),
                .x_in     (cx_w[l][k]),
                .y_in     (cy_w[l][k]),
                .z_in     (cz_w[l][k]),
                .flip_in  (cf_w[l][k]),
                .x_out    (cx_w[l][k+1]),
                .y_out    (cy_w[l][k+1]),
                .z_out    (cz_w[l][k+1]),
                .flip_out (cf_w[l][k+1])
            );
        end
    end

    // Undo the fold and clamp cos/sin to [-1, 1] in Q1.30
    exvr_pkg::q30_t cos_reg [LANES];
    exvr_pkg::q30_t sin_reg [LANES];
    exvr_pkg::q30_t cos_next [LANES];
    exvr_pkg::q30_t sin_next [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            cos_next[l] = cf_w[l][N] ? -cx_w[l][N] : cx_w[l][N];
            sin_next[l] = cf_w[l][N] ? -cy_w[l][N] : cy_w[l][N];
            if (cos_next[l] > exvr_pkg::HALF_PI) begin
                cos_next[l] = exvr_pkg::HALF_PI;
            end else if (cos_next[l] < exvr_pkg::NEG_HALF_PI) begin
                cos_next[l] = exvr_pkg::NEG_HALF_PI;
            end
            if (sin_next[l] > exvr_pkg::HALF_PI) begin
                sin_next[l] = exvr_pkg::HALF_PI;
            end else if (sin_next[l] < exvr_pkg::NEG_HALF_PI) begin
                sin_next[l] = exvr_pkg::NEG_HALF_PI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                cos_reg[l] <= cos_next[l];
                sin_reg[l] <= sin_next[l];
            end
        end
    end

    // Delay the y-axis pair by one rotation and the z-axis pair by two
    exvr_pkg::q30_t cos_y_dly_reg [2];
    exvr_pkg::q30_t sin_y_dly_reg [2];
    exvr_pkg::q30_t cos_z_dly_reg [4];
    exvr_pkg::q30_t sin_z_dly_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            cos_y_dly_reg[0] <= cos_reg[1];
            sin_y_dly_reg[0] <= sin_reg[1];
            cos_y_dly_reg[1] <= cos_y_dly_reg[0];
            sin_y_dly_reg[1] <= sin_y_dly_reg[0];
            cos_z_dly_reg[0] <= cos_reg[2];
            sin_z_dly_reg[0] <= sin_reg[2];
            for (int k = 1; k < 4; k++) begin
                cos_z_dly_reg[k] <= cos_z_dly_reg[k-1];
                sin_z_dly_reg[k] <= sin_z_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Vector delay line: carry the components alongside the CORDIC rows
    // ------------------------------------------------------------------
    logic signed [31:0] vx_reg [N+1];
    logic signed [31:0] vy_reg [N+1];
    logic signed [31:0] vz_reg [N+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx_reg[0] <= ent_x;
            vy_reg[0] <= ent_y;
            vz_reg[0] <= ent_z;
            for (int k = 1; k <= N; k++) begin
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
                vz_reg[k] <= vz_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Three rotations in sequence; each rotates a pair and passes the third
    // component through
    // ------------------------------------------------------------------
    exvr_pkg::comp_t x1_w, y1_w, z1_w;
    exvr_pkg::comp_t x2_w, y2_w, z2_w;
    exvr_pkg::comp_t x3_w, y3_w, z3_w;

    // about x: y' = y c - z s, z' = y s + z c
    exvr_rotate_stage u_rot_x (
        .aclk  (aclk),
        .en    (adv),
        .p_in  (exvr_pkg::COMP_W'(vy_reg[N])),
        .q_in  (exvr_pkg::COMP_W'(vz_reg[N])),
        .r_in  (exvr_pkg::COMP_W'(vx_reg[N])),
        .c_in  (cos_reg[0]),
        .s_in  (sin_reg[0]),
        .p_out (y1_w),
        .q_out (z1_w),
        .r_out (x1_w)
    );

    // about y: z' = z c - x s, x' = z s + x c
    exvr_rotate_stage u_rot_y (
        .aclk  (aclk),
        .en    (adv),
        .p_in  (z1_w),
        .q_in  (x1_w),
        .r_in  (y1_w),
        .c_in  (cos_y_dly_reg[1]),
        .s_in  (sin_y_dly_reg[1]),
        .p_out (z2_w),
        .q_out (x2_w),
        .r_out (y2_w)
    );

    // about z: x' = x c - y s, y' = x s + y c
    exvr_rotate_stage u_rot_z (
        .aclk  (aclk),
        .en    (adv),
        .p_in  (x2_w),
        .q_in  (y2_w),
        .r_in  (z2_w),
        .c_in  (cos_z_dly_reg[3]),
        .s_in  (sin_z_dly_reg[3]),
        .p_out (x3_w),
        .q_out (y3_w),
        .r_out (z3_w)
    );

    // ------------------------------------------------------------------
    // Saturate to 32 bits into the output register
    // ------------------------------------------------------------------
    exvr_pkg::sat_t sat_x, sat_y, sat_z;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               ovf_reg;

    assign sat_x = exvr_pkg::sat32(x3_w);
    assign sat_y = exvr_pkg::sat32(y3_w);
    assign sat_z = exvr_pkg::sat32(z3_w);

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_x_reg <= sat_x.val;
            out_y_reg <= sat_y.val;
            out_z_reg <= sat_z.val;
            ovf_reg   <= sat_x.ovf | sat_y.ovf | sat_z.ovf;
        end
    end

    assign m_valid    = vld_reg[LAT-1];
    assign m_out_x    = out_x_reg;
    assign m_out_y    = out_y_reg;
    assign m_out_z    = out_z_reg;
    assign m_overflow = ovf_reg;

endmodule

// ===== rtl/exvr_checker.sv =====
// Port-level assertions for the Euler XYZ vector rotator, bound to the top level.
module exvr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [31:0]  m_out_x,
    input logic signed [31:0]  m_out_y,
    input logic signed [31:0]  m_out_z,
    input logic                m_overflow
);

    // A stalled item holds its place and its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
                                && $stable(m_out_z) && $stable(m_overflow))
        else $error("result item changed while stalled");

    // Overflow only alongside a component at a 32-bit bound
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |->
            m_out_x == 32'sh7fffffff || m_out_x == 32'sh80000000 ||
            m_out_y == 32'sh7fffffff || m_out_y == 32'sh80000000 ||
            m_out_z == 32'sh7fffffff || m_out_z == 32'sh80000000)
        else $error("overflow flagged without a saturated component");

    // The input side only backs up behind a waiting result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input not ready with no result waiting");

    // Ready drops only after an item was taken into the skid register
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid) && $past(m_valid) && !$past(m_ready))
        else $error("input ready dropped without a stalled accept");

    // Nothing is presented straight after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("valid or ready wrong after reset");

endmodule

bind euler_xyz_vector_rotate exvr_checker u_exvr_checker (.*);
